### hw/rtl/bdq_pkg.sv
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

  // Operation codes
  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_FIND       = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  // Input beat
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] position;
  } out_t;

  // Result handed from the controller to the output register
  typedef struct packed {
    logic done;
    out_t res;
  } ctrl_res_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } ctrl_state_t;

endpackage

### hw/rtl/bdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bdq_ctrl.sv
// Deque controller: ring pointers, operation decode and the find scan over the memory.
module bdq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  bdq_pkg::in_t             in_item,
  output logic                     busy,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [31:0]              ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [31:0]              ram_rdata,
  output bdq_pkg::ctrl_res_t       res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  bdq_pkg::ctrl_state_t state_r, state_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [CNT_W-1:0]   rd_off_r, rd_off_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_off_r, cmp_off_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  logic             hit;
  logic             last;
  logic             scan_done;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W:0]   pos_full;

  // (base + off) mod DEPTH, with base < DEPTH and off < DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [SUM_W-1:0] off);
    logic [SUM_W-1:0] sum;
    begin
      sum = SUM_W'(base) + off;
      if (sum >= DEPTH_S) begin
        sum = sum - DEPTH_S;
      end
      return IDX_W'(sum);
    end
  endfunction

  assign accept    = start && (state_r == bdq_pkg::S_IDLE);
  assign busy      = (state_r != bdq_pkg::S_IDLE);
  assign full      = (count_r == DEPTH_C);
  assign empty     = (count_r == '0);
  assign cnt_m1    = count_r - CNT_W'(1);
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - IDX_W'(1);

  // scan compare stage: data for cmp_off_r arrives this cycle
  assign hit       = (ram_rdata == key_r);
  assign last      = (cmp_off_r == IDX_W'(cnt_m1));
  assign scan_done = cmp_vld_r && (hit || last);
  assign pos_full  = SUM_W'(cmp_off_r) + SUM_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdq_pkg::S_IDLE: begin
        if (accept && (in_item.func == bdq_pkg::FN_FIND) && !empty) begin
          state_nxt = bdq_pkg::S_SCAN;
        end
      end
      bdq_pkg::S_SCAN: begin
        if (scan_done) begin
          state_nxt = bdq_pkg::S_IDLE;
        end
      end
      default: state_nxt = bdq_pkg::S_IDLE;
    endcase
  end

  // datapath, memory access and result
  always_comb begin
    front_nxt    = front_r;
    count_nxt    = count_r;
    key_nxt      = key_r;
    rd_off_nxt   = rd_off_r;
    cmp_vld_nxt  = 1'b0;
    cmp_off_nxt  = cmp_off_r;
    ram_we       = 1'b0;
    ram_waddr    = front_r;
    ram_wdata    = in_item.value;
    ram_re       = 1'b0;
    ram_raddr    = front_r;
    res.done     = 1'b0;
    res.res      = '{status: bdq_pkg::STAT_OK, position: 5'd0};
    case (state_r)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          res.done = 1'b1;
          case (in_item.func)
            bdq_pkg::FN_PUSH_FRONT: begin
              if (full) begin
                res.res.status = bdq_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            bdq_pkg::FN_PUSH_BACK: begin
              if (full) begin
                res.res.status = bdq_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(front_r, SUM_W'(count_r));
                count_nxt = count_r + CNT_W'(1);
              end
            end
            bdq_pkg::FN_POP_FRONT: begin
              if (empty) begin
                res.res.status = bdq_pkg::STAT_EMPTY;
              end else begin
                front_nxt = ring_add(front_r, SUM_W'(1));
                count_nxt = cnt_m1;
              end
            end
            bdq_pkg::FN_POP_BACK: begin
              if (empty) begin
                res.res.status = bdq_pkg::STAT_EMPTY;
              end else begin
                count_nxt = cnt_m1;
              end
            end
            bdq_pkg::FN_FIND: begin
              if (empty) begin
                res.res.status = bdq_pkg::STAT_EMPTY;
              end else begin
                res.done   = 1'b0;
                key_nxt    = in_item.value;
                rd_off_nxt = '0;
              end
            end
            default: ;  // unused codes: no change, status ok
          endcase
        end
      end
      bdq_pkg::S_SCAN: begin
        // issue stage: one read per cycle, front to back
        if (rd_off_r < count_r) begin
          ram_re      = 1'b1;
          ram_raddr   = ring_add(front_r, SUM_W'(rd_off_r));
          rd_off_nxt  = rd_off_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_off_nxt = IDX_W'(rd_off_r);
        end
        // compare stage
        if (cmp_vld_r) begin
          if (hit) begin
            res.done             = 1'b1;
            res.res.position     = 5'(pos_full);
          end else if (last) begin
            res.done             = 1'b1;
            res.res.status       = bdq_pkg::STAT_NOTFOUND;
          end
        end
        if (scan_done) begin
          cmp_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bdq_pkg::S_IDLE;
      front_r   <= '0;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      rd_off_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      rd_off_r  <= rd_off_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    cmp_off_r <= cmp_off_nxt;
  end

endmodule

### hw/rtl/bounded_deque_with_search.sv
// Push, pop and no-op beats, and a find on an empty deque, give the result strobe in the cycle after start; no busy.
// Find: busy while the scan runs (one ring read per cycle, front to back, each read compared when
//   its registered data returns); the result strobe comes in the cycle busy falls.
// Throughput: a new beat every cycle, except behind a find, which holds busy until its result.
// Reset (synchronous, rst_n low) empties the queue and sets the front slot to 0; memory
//   contents are not cleared. Results are not held off by the receiver.
module bounded_deque_with_search #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bdq_pkg::in_t   in_item,
  output logic           out_valid,
  output bdq_pkg::out_t  out_item
);

  localparam int IDX_W = $clog2(DEPTH);

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [31:0]        ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [31:0]        ram_rdata;
  bdq_pkg::ctrl_res_t res;
  logic               out_valid_r;
  bdq_pkg::out_t      out_item_r;

  bdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .res      (res)
  );

  bdq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // result strobe register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.done;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (res.done) begin
      out_item_r <= res.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### hw/rtl/bdq_checker.sv
// Port-level checks for the bounded deque, bound to the top level.
module bdq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input bdq_pkg::in_t  in_item,
  input logic          out_valid,
  input bdq_pkg::out_t out_item
);

  // any beat other than find gives its result in the next cycle, with busy low
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.func != bdq_pkg::FN_FIND)) |=> (out_valid && !busy))
    else $error("non-find beat did not produce a result in the next cycle");

  // a find either raises busy or, on an empty deque, gives its result in the following cycle
  a_find_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.func == bdq_pkg::FN_FIND)) |=> (out_valid != busy))
    else $error("find beat produced neither busy nor a result");

  // results never show while a scan is still running
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a nonzero position only comes with a successful find
  a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.position != 5'd0)) |-> (out_item.status == bdq_pkg::STAT_OK))
    else $error("position reported with a failing status");

  // reset returns the block to idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);

### tb/sv/testbench.sv
// Self-checking testbench for the bounded deque with search.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 880;

  logic          clk;
  logic          rst_n   = 1'b0;
  logic          start   = 1'b0;
  bdq_pkg::in_t  in_item = '0;
  logic          busy;
  logic          out_valid;
  bdq_pkg::out_t out_item;

  bounded_deque_with_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the deque contents
  logic signed [31:0] shadow_slots [DEPTH];
  int unsigned        shadow_front = 0;
  int unsigned        shadow_fill  = 0;

  bdq_pkg::out_t awaited_replies [$];
  bdq_pkg::out_t predicted_reply;
  int            errors     = 0;
  int            burst_left = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  // Apply one beat to the shadow deque and return the reply it should produce
  function automatic bdq_pkg::out_t deque_predict(input bdq_pkg::in_t beat);
    bdq_pkg::out_t r;
    int unsigned   k;
    r.status   = bdq_pkg::STAT_OK;
    r.position = '0;
    case (beat.func)
      bdq_pkg::FN_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = bdq_pkg::STAT_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_slots[shadow_front] = beat.value;
          shadow_fill++;
        end
      end
      bdq_pkg::FN_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          r.status = bdq_pkg::STAT_FULL;
        end else begin
          shadow_slots[(shadow_front + shadow_fill) % DEPTH] = beat.value;
          shadow_fill++;
        end
      end
      bdq_pkg::FN_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = bdq_pkg::STAT_EMPTY;
        end else begin
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_fill--;
        end
      end
      bdq_pkg::FN_POP_BACK: begin
        if (shadow_fill == 0) r.status = bdq_pkg::STAT_EMPTY;
        else shadow_fill--;
      end
      bdq_pkg::FN_FIND: begin
        if (shadow_fill == 0) begin
          r.status = bdq_pkg::STAT_EMPTY;
        end else begin
          r.status = bdq_pkg::STAT_NOTFOUND;
          for (k = 0; k < shadow_fill; k++) begin
            if (shadow_slots[(shadow_front + k) % DEPTH] == beat.value) begin
              r.status   = bdq_pkg::STAT_OK;
              r.position = 5'(k + 1);
              break;
            end
          end
        end
      end
      default: ;  // unused codes leave the deque alone
    endcase
    return r;
  endfunction

  // Result check, then prediction for a beat taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d pos=%0d",
                                    out_item.status, out_item.position));
        end else begin
          predicted_reply = awaited_replies.pop_front();
          if (out_item.status !== predicted_reply.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_item.status, predicted_reply.status));
          if (out_item.position !== predicted_reply.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      out_item.position, predicted_reply.position));
        end
      end
      if (start && !busy) awaited_replies.push_back(deque_predict(in_item));
    end
  end

  // Send one beat, hold it until taken, then maybe pause between bursts
  task automatic send_beat(input logic [2:0] fn, input logic signed [31:0] v);
    bdq_pkg::in_t beat;
    int           gap;
    beat.func  = fn;
    beat.value = v;
    start   <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (busy);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start   <= 1'b0;
        in_item <= bdq_pkg::in_t'({3'($urandom_range(0, 7)), 32'($urandom())});
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'($urandom_range(0, 7));
      3:       return -32'sd1 * 32'($urandom_range(1, 8));
      default: return 32'($urandom());
    endcase
  endfunction

  // Pops and finds against an empty deque
  task automatic test_empty_queue();
    send_beat(bdq_pkg::FN_POP_FRONT, 32'sd5);
    send_beat(bdq_pkg::FN_POP_BACK, -32'sd5);
    send_beat(bdq_pkg::FN_FIND, 32'sd0);
  endtask

  // Value extremes at both ends, unused codes, popping down to empty
  task automatic test_ends_and_noops();
    send_beat(bdq_pkg::FN_PUSH_FRONT, 32'sh8000_0000);
    send_beat(bdq_pkg::FN_PUSH_BACK, 32'sh7fff_ffff);
    send_beat(bdq_pkg::FN_PUSH_FRONT, 32'sd0);
    send_beat(bdq_pkg::FN_FIND, 32'sh7fff_ffff);
    send_beat(bdq_pkg::FN_FIND, 32'sh8000_0000);
    send_beat(bdq_pkg::FN_FIND, -32'sd1);
    send_beat(3'd5, -32'sd1);
    send_beat(3'd6, 32'sh7fff_ffff);
    send_beat(3'd7, 32'sh8000_0000);
    send_beat(bdq_pkg::FN_POP_BACK, 32'sd0);
    send_beat(bdq_pkg::FN_POP_FRONT, 32'sd0);
    send_beat(bdq_pkg::FN_POP_FRONT, 32'sd0);   // last entry leaves
    send_beat(bdq_pkg::FN_POP_FRONT, 32'sd0);
  endtask

  // Fill to capacity with a duplicate, then pushes into a full deque
  task automatic test_full_queue();
    int i;
    for (i = 0; i < DEPTH; i++)
      send_beat(i[0] ? bdq_pkg::FN_PUSH_FRONT : bdq_pkg::FN_PUSH_BACK,
                (i == 4 || i == 9) ? 32'sd7 : 32'(100 + i));
    send_beat(bdq_pkg::FN_PUSH_FRONT, 32'sd1);
    send_beat(bdq_pkg::FN_PUSH_BACK, 32'sd2);
    send_beat(bdq_pkg::FN_FIND, 32'sd7);        // first of two matches
    send_beat(bdq_pkg::FN_FIND, 32'sd114);      // back end, position 16
    send_beat(bdq_pkg::FN_POP_FRONT, 32'sd0);
    send_beat(bdq_pkg::FN_PUSH_BACK, -32'sd9);
  endtask

  // Random traffic; the push/pop lean changes to sweep between full and empty
  task automatic test_random_mix(input int n);
    int               i;
    int               lean;
    int               r;
    logic [2:0]       fn;
    logic signed [31:0] v;
    lean = 2;
    for (i = 0; i < n; i++) begin
      if (i % 60 == 0) lean = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      v = pick_value();
      if (r < 3) begin
        fn = 3'($urandom_range(5, 7));
      end else if (r < 25) begin
        fn = bdq_pkg::FN_FIND;
        if (shadow_fill != 0 && $urandom_range(0, 9) < 6)
          v = shadow_slots[(shadow_front + $urandom_range(0, shadow_fill - 1)) % DEPTH];
      end else begin
        r = $urandom_range(0, 99);
        if ((lean == 0 && r < 75) || (lean == 1 && r < 25) || (lean == 2 && r < 50))
          fn = $urandom_range(0, 1) ? bdq_pkg::FN_PUSH_FRONT : bdq_pkg::FN_PUSH_BACK;
        else
          fn = $urandom_range(0, 1) ? bdq_pkg::FN_POP_FRONT : bdq_pkg::FN_POP_BACK;
      end
      send_beat(fn, v);
    end
  endtask

  // Hang guard
  initial begin
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("TIMEOUT after %0d cycles", CYCLE_LIMIT);
    $display("bounded_deque_with_search regression: fail");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_ends_and_noops();
    test_full_queue();
    test_random_mix(RAND_ITEMS);
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (errors == 0) begin
      $display("bounded_deque_with_search regression: pass");
    end else begin
      $display("bounded_deque_with_search regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ram.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bounded_deque_with_search.sv
hw/rtl/bdq_checker.sv
tb/sv/testbench.sv
